@@ rtl/mqttrd_pkg.sv @@
// Package for the MQTT receive deframer: phase type, byte role codes,
// register indexes and header constants. No dependencies.
package mqttrd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_TOPIC_HI = 3'd2,
        PH_TOPIC_LO = 3'd3,
        PH_BODY     = 3'd4
    } t_phase;

    localparam logic [2:0] ROLE_HEADER    = 3'd0;
    localparam logic [2:0] ROLE_LENGTH    = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
    localparam logic [2:0] ROLE_TOPIC     = 3'd3;
    localparam logic [2:0] ROLE_MSG_ID    = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD   = 3'd5;

    localparam logic REG_MAX_PACKET_SIZE = 1'b0;
    localparam logic REG_STREAM_ATTACHED = 1'b1;

    localparam int          APB_ADDR_W       = 3;
    localparam logic [3:0]  TYPE_PUBLISH     = 4'h3;
    localparam int          QOS1_BIT         = 1;
    localparam int          LEN_MORE_BIT     = 7;
    localparam logic [15:0] MAX_PACKET_RESET = 16'd128;

endpackage

@@ rtl/mqtt_receive_deframer_core.sv @@
// MQTT receive deframer top level: input register, per-byte parser, result register,
// and APB configuration registers. Depends on mqttrd_pkg.
//
// Usage:
//   Slave stream (i_s_*) takes one received MQTT byte per request in tdata[7:0].
//   Master stream (o_m_*) gives one tagged result per byte: the byte, its
//   packet length and length-field count in tdata, its role, packet type,
//   forward and drop flags in tuser, and tlast on the final byte of a packet.
//   APB port: register 0 max_packet_size at 0x0, register 1 stream_attached at 0x4.
//   Write configuration only while no byte is in flight.
// Pipeline: input register, then parser into the result register.
// Throughput: one byte per cycle while i_m_tready is high; the phase and counter
//   registers update together with the result register.
// Reset: synchronous; the parser expects a header byte, counters clear,
//   max_packet_size returns to 128 and stream_attached to 0.
// Stall: when i_m_tready is low the result holds, the input register keeps one
//   more byte, and o_s_tready drops once both are full.
module mqtt_receive_deframer_core
    import mqttrd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [39:0]           o_m_tdata,   // [7:0] data_byte, [36:8] packet_length,
                                               // [39:37] length_field_bytes
    output logic [8:0]            o_m_tuser,   // [2:0] byte_role, [6:3] packet_type,
                                               // [7] forward_to_stream, [8] dropped
    output logic                  o_m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] r_max;
    logic        r_stream;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_header, n_header;
    logic [27:0] r_rem, n_rem;
    logic [2:0]  r_lbc, n_lbc;
    logic [15:0] r_topic, n_topic;
    logic [27:0] r_body, n_body;
    logic [28:0] r_total, n_total;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [2:0]  r_out_role;
    logic [3:0]  r_out_type;
    logic        r_out_fwd;
    logic        r_out_last;
    logic [28:0] r_out_plen;
    logic [2:0]  r_out_lfb;
    logic        r_out_drop;

    logic        adv;
    logic        fire;
    logic        cfg_wr;

    logic [2:0]  c_role;
    logic        c_fwd;
    logic        c_last;
    logic [28:0] c_plen;
    logic [2:0]  c_lfb;
    logic        c_drop;
    logic        is_pub;
    logic [4:0]  shamt;
    logic [27:0] k;
    logic [16:0] skip;

    assign adv    = !r_out_valid || i_m_tready;
    assign fire   = r_in_valid && adv;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign o_s_tready = !r_in_valid || adv;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_STREAM_ATTACHED) ? {31'd0, r_stream} : {16'd0, r_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_PACKET_RESET;
            r_stream <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_PACKET_SIZE: r_max    <= pwdata[15:0];
                REG_STREAM_ATTACHED: r_stream <= pwdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_rem    = r_rem;
        n_lbc    = r_lbc;
        n_topic  = r_topic;
        n_body   = r_body;
        n_total  = r_total + 29'd1;
        c_role   = ROLE_HEADER;
        c_fwd    = 1'b0;
        c_last   = 1'b0;
        is_pub   = (r_header[7:4] == TYPE_PUBLISH);
        shamt    = 5'(r_lbc[1:0]) * 5'd7;
        k        = r_body - 28'd2;
        skip     = {1'b0, r_topic} + (r_header[QOS1_BIT] ? 17'd2 : 17'd0);

        unique case (r_phase)
            PH_LENGTH: begin
                c_role = ROLE_LENGTH;
                n_rem  = r_rem | (28'(r_in_byte[6:0]) << shamt);
                n_lbc  = r_lbc + 3'd1;
                if (!r_in_byte[LEN_MORE_BIT] || n_lbc >= 3'(MAX_LENGTH_BYTES)) begin
                    if (is_pub) begin
                        n_phase = PH_TOPIC_HI;
                    end else if (n_rem == 28'd0) begin
                        c_last = 1'b1;
                    end else begin
                        n_body  = 28'd0;
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_TOPIC_HI: begin
                c_role  = ROLE_TOPIC_LEN;
                n_topic = {r_in_byte, 8'd0};
                n_phase = PH_TOPIC_LO;
            end
            PH_TOPIC_LO: begin
                c_role  = ROLE_TOPIC_LEN;
                n_topic = {r_topic[15:8], r_in_byte};
                n_body  = 28'd2;
                if (r_rem <= 28'd2) begin
                    c_last = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                c_role = ROLE_PAYLOAD;
                if (is_pub) begin
                    if (k < {12'd0, r_topic}) begin
                        c_role = ROLE_TOPIC;
                    end else if (k < {11'd0, skip}) begin
                        c_role = ROLE_MSG_ID;
                    end else begin
                        c_fwd = r_stream;
                    end
                end
                n_body = r_body + 28'd1;
                if (n_body >= r_rem) begin
                    c_last = 1'b1;
                end
            end
            default: begin
                n_header = r_in_byte;
                n_rem    = 28'd0;
                n_lbc    = 3'd0;
                n_topic  = 16'd0;
                n_body   = 28'd0;
                n_total  = 29'd1;
                n_phase  = PH_LENGTH;
            end
        endcase

        c_plen = 29'd0;
        c_lfb  = 3'd0;
        c_drop = 1'b0;
        if (c_last) begin
            c_plen  = n_total;
            c_lfb   = n_lbc;
            c_drop  = !r_stream && (n_total > {13'd0, r_max});
            n_phase = PH_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_header <= 8'd0;
            r_rem    <= 28'd0;
            r_lbc    <= 3'd0;
            r_topic  <= 16'd0;
            r_body   <= 28'd0;
            r_total  <= 29'd0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_rem    <= n_rem;
            r_lbc    <= n_lbc;
            r_topic  <= n_topic;
            r_body   <= n_body;
            r_total  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= r_in_byte;
            r_out_role <= c_role;
            r_out_type <= n_header[7:4];
            r_out_fwd  <= c_fwd;
            r_out_last <= c_last;
            r_out_plen <= c_plen;
            r_out_lfb  <= c_lfb;
            r_out_drop <= c_drop;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_lfb, r_out_plen, r_out_byte};
    assign o_m_tuser  = {r_out_drop, r_out_fwd, r_out_type, r_out_role};
    assign o_m_tlast  = r_out_last;

endmodule

@@ rtl/mqttrd_checker.sv @@
// Port-level checker for the MQTT receive deframer, with its bind statement.
// Depends on mqttrd_pkg and mqtt_receive_deframer_core.
module mqttrd_checker
    import mqttrd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic [8:0]  i_m_tuser,
    input logic        i_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tlast |-> i_m_tdata[39:8] == 32'd0 && !i_m_tuser[8])
        else $error("length fields or drop set off last byte");

    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[2:0] == ROLE_HEADER |-> !i_m_tlast)
        else $error("packet ended on its header byte");

    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[7] |-> i_m_tuser[2:0] == ROLE_PAYLOAD && !i_m_tuser[8])
        else $error("forward on a non-payload byte");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tdata[36:8] >= 29'd2)
        else $error("packet shorter than two bytes");

endmodule

bind mqtt_receive_deframer_core mqttrd_checker u_mqttrd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

@@ sim/mqtt_receive_deframer_core_tb.sv @@
// Self-checking testbench for mqtt_receive_deframer_core: streams MQTT packets byte by
// byte, predicts every tagged result and checks it against the master stream.
// Depends on mqttrd_pkg and the mqtt_receive_deframer_core RTL.
module mqtt_receive_deframer_core_tb;
    import mqttrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN_BYTES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  role;
        logic [3:0]  ptype;
        logic        fwd;
        logic        last;
        logic [28:0] pkt_len;
        logic [2:0]  len_bytes;
        logic        dropped;
    } t_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [39:0]           o_m_tdata;
    logic [8:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    mqtt_receive_deframer_core #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial forever #1 i_clk = ~i_clk;

    logic [7:0] plan_q[$];
    logic [7:0] rx_bytes_q[$];
    t_result    tagged_q[$];

    int bytes_queued = 0;
    int results_seen = 0;
    int err_cnt      = 0;
    int idle_cycles  = 0;
    int src_gap      = 0;
    int snk_stall    = 0;
    bit src_calm     = 1'b0;
    bit snk_calm     = 1'b0;

    // parser shadow state and register copies
    t_phase      fr_phase     = PH_HEADER;
    logic [7:0]  fr_hdr       = '0;
    logic [27:0] fr_rem       = '0;
    logic [2:0]  fr_len_cnt   = '0;
    logic [15:0] fr_topic_len = '0;
    logic [27:0] fr_body_cnt  = '0;
    logic [28:0] fr_total     = '0;
    logic [15:0] cfg_max_size = MAX_PACKET_RESET;
    logic        cfg_stream   = 1'b0;

    t_result seen;
    t_result want;

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result     t;
        logic [31:0] k;
        logic [31:0] skip;
        t = '0;
        t.data_byte = b;
        if (fr_phase == PH_HEADER) begin
            fr_hdr       = b;
            fr_rem       = '0;
            fr_len_cnt   = '0;
            fr_topic_len = '0;
            fr_body_cnt  = '0;
            fr_total     = 29'd1;
            t.role       = ROLE_HEADER;
            fr_phase     = PH_LENGTH;
        end else begin
            fr_total = fr_total + 29'd1;
            case (fr_phase)
                PH_LENGTH: begin
                    t.role     = ROLE_LENGTH;
                    fr_rem     = fr_rem | (28'(b[6:0]) << (7 * fr_len_cnt[1:0]));
                    fr_len_cnt = fr_len_cnt + 3'd1;
                    if (!b[LEN_MORE_BIT] || fr_len_cnt >= 3'(MAX_LEN_BYTES)) begin
                        if (fr_hdr[7:4] == TYPE_PUBLISH) begin
                            fr_phase = PH_TOPIC_HI;
                        end else if (fr_rem == '0) begin
                            t.last = 1'b1;
                        end else begin
                            fr_body_cnt = '0;
                            fr_phase    = PH_BODY;
                        end
                    end
                end
                PH_TOPIC_HI: begin
                    t.role       = ROLE_TOPIC_LEN;
                    fr_topic_len = {b, 8'h00};
                    fr_phase     = PH_TOPIC_LO;
                end
                PH_TOPIC_LO: begin
                    t.role       = ROLE_TOPIC_LEN;
                    fr_topic_len = fr_topic_len | 16'(b);
                    fr_body_cnt  = 28'd2;
                    if (fr_rem <= 28'd2) begin
                        t.last = 1'b1;
                    end else begin
                        fr_phase = PH_BODY;
                    end
                end
                default: begin
                    t.role = ROLE_PAYLOAD;
                    if (fr_hdr[7:4] == TYPE_PUBLISH) begin
                        k    = 32'(fr_body_cnt) - 32'd2;
                        skip = 32'(fr_topic_len) + (fr_hdr[QOS1_BIT] ? 32'd2 : 32'd0);
                        if (k < 32'(fr_topic_len)) begin
                            t.role = ROLE_TOPIC;
                        end else if (k < skip) begin
                            t.role = ROLE_MSG_ID;
                        end else begin
                            t.fwd = cfg_stream;
                        end
                    end
                    fr_body_cnt = fr_body_cnt + 28'd1;
                    if (fr_body_cnt >= fr_rem) begin
                        t.last = 1'b1;
                    end
                end
            endcase
        end
        t.ptype = fr_hdr[7:4];
        if (t.last) begin
            t.pkt_len   = fr_total;
            t.len_bytes = fr_len_cnt;
            t.dropped   = !cfg_stream && (fr_total > 29'(cfg_max_size));
            fr_phase    = PH_HEADER;
        end
        return t;
    endfunction

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                tagged_q.push_back(deframe_byte(i_s_tdata));
                src_gap = src_calm ? 0 : $urandom_range(0, 6);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap != 0) begin
                    src_gap = src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (rx_bytes_q.size() != 0) begin
                    i_s_tdata  <= rx_bytes_q.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen = results_seen + 1;
                seen.data_byte = o_m_tdata[7:0];
                seen.pkt_len   = o_m_tdata[36:8];
                seen.len_bytes = o_m_tdata[39:37];
                seen.role      = o_m_tuser[2:0];
                seen.ptype     = o_m_tuser[6:3];
                seen.fwd       = o_m_tuser[7];
                seen.dropped   = o_m_tuser[8];
                seen.last      = o_m_tlast;
                if (tagged_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("unexpected result: byte %h role %0d", seen.data_byte,
                                 seen.role);
                end else begin
                    want = tagged_q.pop_front();
                    if (seen !== want) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display("mismatch %0d (exp/act): byte %h/%h role %0d/%0d",
                                     results_seen, want.data_byte, seen.data_byte,
                                     want.role, seen.role);
                            $display("  type %h/%h fwd %b/%b last %b/%b len %0d/%0d",
                                     want.ptype, seen.ptype, want.fwd, seen.fwd,
                                     want.last, seen.last, want.pkt_len, seen.pkt_len);
                            $display("  lbytes %0d/%0d drop %b/%b",
                                     want.len_bytes, seen.len_bytes,
                                     want.dropped, seen.dropped);
                        end
                    end
                end
                snk_stall = snk_calm ? 0 : $urandom_range(0, 6);
            end
            if (snk_stall != 0) begin
                snk_stall = snk_stall - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_PACKET_SIZE)
            cfg_max_size = value[15:0];
        else
            cfg_stream = value[0];
    endtask

    task automatic plan_packet(input logic [7:0] hdr_b, input int rem, input int n_len,
                               input bit cont_last, input int tl);
        int         n;
        int         body;
        logic [7:0] g;
        n = 1;
        while (n < MAX_LEN_BYTES && (rem >> (7 * n)) != 0) n++;
        if (n_len > n) n = n_len;
        plan_q.push_back(hdr_b);
        for (int i = 0; i < n; i++) begin
            g = 8'((rem >> (7 * i)) & 127);
            if (i < n - 1 || (cont_last && n == MAX_LEN_BYTES)) g[LEN_MORE_BIT] = 1'b1;
            plan_q.push_back(g);
        end
        if (hdr_b[7:4] == TYPE_PUBLISH) begin
            plan_q.push_back(8'(tl >> 8));
            plan_q.push_back(8'(tl));
            body = (rem > 2) ? rem - 2 : 0;
        end else begin
            body = rem;
        end
        for (int i = 0; i < body; i++) plan_q.push_back(8'($urandom));
    endtask

    task automatic plan_random_packet();
        int         kind;
        int         sel;
        int         rem;
        int         room;
        int         tl;
        int         n_len;
        bit         cont_last;
        logic [7:0] h;
        kind = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (sel < 6)
            rem = $urandom_range(3, 40);
        else if (sel < 8)
            rem = $urandom_range(0, 2);
        else
            rem = $urandom_range(100, 300);
        h = 8'($urandom);
        if (kind < 60) h[7:4] = TYPE_PUBLISH;
        room = rem - 2 - (h[QOS1_BIT] ? 2 : 0);
        if (room >= 0 && $urandom_range(0, 9) < 8)
            tl = $urandom_range(0, room);
        else
            tl = $urandom_range(0, 65535);
        sel       = $urandom_range(0, 9);
        n_len     = (sel < 7) ? 0 : (sel < 9) ? $urandom_range(1, MAX_LEN_BYTES) : MAX_LEN_BYTES;
        cont_last = (sel == 9);
        plan_packet(h, rem, n_len, cont_last, tl);
    endtask

    task automatic run_chunk(input int n_bytes);
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_bytes && plan_q.size() != 0; i++) begin
            rx_bytes_q.push_back(plan_q.pop_front());
            bytes_queued = bytes_queued + 1;
        end
        while (results_seen != bytes_queued) @(posedge i_clk);
    endtask

    initial begin
        int chunk;
        int sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length, short publish, max topic length, QoS1 publish, over-long length
        plan_packet(8'hC0, 0, 0, 1'b0, 0);
        plan_packet(8'h30, 0, 0, 1'b0, 0);
        plan_packet(8'h31, 2, 0, 1'b0, 16'hFFFF);
        plan_packet(8'h32, 7, 0, 1'b0, 2);
        plan_packet(8'hFF, 1, MAX_LEN_BYTES, 1'b1, 0);
        run_chunk(plan_q.size());

        while (plan_q.size() < 150) plan_random_packet();
        run_chunk(plan_q.size());

        // one 2-byte length packet just over the size limit
        apb_write_reg(REG_MAX_PACKET_SIZE, 32'd300);
        apb_write_reg(REG_STREAM_ATTACHED, 32'd0);
        plan_packet(8'h90, 298, 0, 1'b0, 0);
        run_chunk(plan_q.size());

        apb_write_reg(REG_MAX_PACKET_SIZE, 32'd1);
        while (plan_q.size() < 500) plan_random_packet();
        chunk = 0;
        while (plan_q.size() != 0) begin
            run_chunk($urandom_range(40, 200));
            chunk++;
            sel = $urandom_range(0, 3);
            if (sel == 0)
                apb_write_reg(REG_MAX_PACKET_SIZE, 32'd1);
            else if (sel == 1)
                apb_write_reg(REG_MAX_PACKET_SIZE, 32'd65535);
            else if (sel == 2)
                apb_write_reg(REG_MAX_PACKET_SIZE, 32'(MAX_PACKET_RESET));
            else
                apb_write_reg(REG_MAX_PACKET_SIZE, 32'($urandom_range(1, 300)));
            apb_write_reg(REG_STREAM_ATTACHED, 32'(chunk % 2));
        end

        repeat (4) @(posedge i_clk);
        if (err_cnt == 0 && tagged_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
